>>> rtl/bb3_pkg.sv
// Shared types, codes and the fixed 3x3 bridge logic for the binary bridge block.
// Used by binary_bridge_3x3_unit; no dependencies.
package bb3_pkg;

  // stream item kind, carried in tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;
  localparam int CFG_DATA_W = 11;

  // row ring: four rows, one bit each per column word
  localparam int RING   = 4;
  localparam int SLOT_W = 2;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = FIFO_AW + 1;

  typedef struct packed {
    logic last;
    logic pixel;
  } out_beat_t;

  // Set pixels pass; a clear pixel is set when foreground on opposite sides
  // would join across it, except for the four diagonal-gap patterns.
  function automatic logic bridge_3x3(
    input logic nw, input logic n,  input logic ne,
    input logic w,  input logic x,  input logic e,
    input logic sw, input logic s,  input logic se
  );
    logic quiet;
    logic gap;
    logic p1, p2, p3, p4, p5, p6;
    quiet = !x && !e && !n && !w && !s;
    gap = quiet && (( ne &&  nw && !sw && !se) ||
                    (!ne &&  nw &&  sw && !se) ||
                    (!ne && !nw &&  sw &&  se) ||
                    ( ne && !nw && !sw &&  se));
    p1 = !n && !s && (nw || w || sw) && (e || ne || se) && !gap;
    p2 = !e && !w && (ne || n || nw) && (sw || s || se) && !gap;
    p3 = !e && !s && se && (n || nw || w);
    p4 = !e && !n && ne && (w || sw || s);
    p5 = !n && !w && nw && (e || s || se);
    p6 = !w && !s && sw && (e || ne || n);
    return x || p1 || p2 || p3 || p4 || p5 || p6;
  endfunction

endpackage

>>> rtl/bb3_ram.sv
// Generic synchronous RAM: one write port with per-bit enables, two read ports.
// Read data is registered and returns the old contents on a same-address write.
module bb3_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [WIDTH-1:0]         wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH; i++) begin
      if (wr_en[i]) begin
        mem[wr_addr][i] <= wr_data[i];
      end
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/binary_bridge_3x3_unit.sv
// Streaming 3x3 binary bridge: top level with row ring, release control and output queue.
// Depends on bb3_pkg and bb3_ram.

// One pixel is taken per clock while s_axis_tready is high. Results come out in
// row-major order, each one released by an input beat once every pixel up to
// its lower-right neighbour (clamped to the frame) is in, so the output trails
// the input by about one row plus two pixels, and flush beats drain the rest
// after the frame's last pixel. The last four rows live in one RAM of MAX_COLS
// words, four bits wide (one bit per ring row); each beat costs one bit write and
// two column reads, so the RAM ports set the one-per-clock rate. A four-entry
// output queue lets input continue while results wait; s_axis_tready drops only
// when the queue and the read and compute stages hold four results. Windows read
// only pixels of the current frame, so the RAM needs no clearing after reset. A
// configuration write aborts the frame in progress.
module binary_bridge_3x3_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [0] pixel_in
  input  logic                            s_axis_tuser,   // [0] action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [0] pixel_out
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [bb3_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam int ROWS_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

  // geometry, stored as last index
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [CW-1:0] cfg_last_col;
  logic [RW-1:0] cfg_last_row;

  // stream position
  logic [CW-1:0] in_col, in_col_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [CW-1:0] out_col, out_col_next;
  logic [RW-1:0] out_row, out_row_next;
  logic          frame_done, frame_done_next;

  logic          in_acc;
  logic          pix_take;
  logic          rel;
  logic          out_last;
  logic [CW-1:0] lr_col;
  logic [RW-1:0] lr_row;
  logic [SLOT_W-1:0] slot_up, slot_mid, slot_dn;

  // read stage
  logic              s1_valid;
  logic              s1_c0;
  logic              s1_last;
  logic [CW-1:0]     s1_col;
  logic [CW-1:0]     s1_col_r;
  logic [SLOT_W-1:0] s1_up, s1_mid, s1_dn;

  // compute stage
  logic              s2_valid;
  logic              s2_c0;
  logic              s2_last;
  logic [SLOT_W-1:0] s2_up, s2_mid, s2_dn;
  logic [RING-1:0]   prev_center;

  logic [RING-1:0] ram_wr_en;
  logic [RING-1:0] col_right, col_center, col_left;
  out_beat_t       res;

  // output queue
  out_beat_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fifo_count;
  logic               push, pop;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // clamp written geometry: 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    if (cfg_data == '0) begin
      cfg_last_col = '0;
    end else if (int'(cfg_data) > MAX_COLS) begin
      cfg_last_col = CW'(MAX_COLS - 1);
    end else begin
      cfg_last_col = CW'(cfg_data - 1'b1);
    end
    if (cfg_data == '0) begin
      cfg_last_row = '0;
    end else if (int'(cfg_data) > MAX_ROWS) begin
      cfg_last_row = RW'(MAX_ROWS - 1);
    end else begin
      cfg_last_row = RW'(cfg_data - 1'b1);
    end
  end

  always_comb begin
    pix_take        = in_acc && (s_axis_tuser == ACT_PIXEL) && !frame_done;
    in_col_next     = in_col;
    in_row_next     = in_row;
    frame_done_next = frame_done;
    out_col_next    = out_col;
    out_row_next    = out_row;

    if (pix_take) begin
      if (in_col == last_col) begin
        in_col_next = '0;
        if (in_row == last_row) begin
          frame_done_next = 1'b1;
        end else begin
          in_row_next = in_row + 1'b1;
        end
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end

    // lower-right neighbour of the next pending result, clamped
    lr_row = (out_row == last_row) ? out_row : out_row + 1'b1;
    lr_col = (out_col == last_col) ? out_col : out_col + 1'b1;

    rel = in_acc && (frame_done_next || (in_row_next > lr_row) ||
                     ((in_row_next == lr_row) && (in_col_next > lr_col)));
    out_last = (out_row == last_row) && (out_col == last_col);

    if (rel) begin
      if (out_last) begin
        in_col_next     = '0;
        in_row_next     = '0;
        out_col_next    = '0;
        out_row_next    = '0;
        frame_done_next = 1'b0;
      end else if (out_col == last_col) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end

    // ring slots of the rows above, at and below the result, clamped
    slot_mid = out_row[SLOT_W-1:0];
    slot_up  = (out_row == '0) ? slot_mid : slot_mid - 1'b1;
    slot_dn  = (out_row == last_row) ? slot_mid : slot_mid + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col   <= CW'(COLS_RST - 1);
      last_row   <= RW'(ROWS_RST - 1);
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      frame_done <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_COLS: begin
          last_col   <= cfg_last_col;
          in_col     <= '0;
          in_row     <= '0;
          out_col    <= '0;
          out_row    <= '0;
          frame_done <= 1'b0;
        end
        REG_FRAME_ROWS: begin
          last_row   <= cfg_last_row;
          in_col     <= '0;
          in_row     <= '0;
          out_col    <= '0;
          out_row    <= '0;
          frame_done <= 1'b0;
        end
        default: begin
        end
      endcase
    end else begin
      in_col     <= in_col_next;
      in_row     <= in_row_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
      frame_done <= frame_done_next;
    end
  end

  // write the incoming pixel into its row slot
  assign ram_wr_en = pix_take ? (RING'(1) << in_row[SLOT_W-1:0]) : '0;

  bb3_ram #(
    .WIDTH (RING),
    .DEPTH (MAX_COLS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (in_col),
    .wr_data   ({RING{s_axis_tdata[0]}}),
    .rd_addr_a (s1_col_r),
    .rd_data_a (col_right),
    .rd_addr_b (s1_col),
    .rd_data_b (col_center)
  );

  // read in the cycle after release so the pixel written with it is visible
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= rel;
      s2_valid <= s1_valid;
    end
    s1_c0    <= (out_col == '0);
    s1_last  <= out_last;
    s1_col   <= out_col;
    s1_col_r <= lr_col;
    s1_up    <= slot_up;
    s1_mid   <= slot_mid;
    s1_dn    <= slot_dn;
    s2_c0    <= s1_c0;
    s2_last  <= s1_last;
    s2_up    <= s1_up;
    s2_mid   <= s1_mid;
    s2_dn    <= s1_dn;
    if (s2_valid) begin
      prev_center <= col_center;
    end
  end

  // left column repeats the center at the row start, else is the last center
  always_comb begin
    col_left  = s2_c0 ? col_center : prev_center;
    res.last  = s2_last;
    res.pixel = bridge_3x3(col_left[s2_up],  col_center[s2_up],  col_right[s2_up],
                           col_left[s2_mid], col_center[s2_mid], col_right[s2_mid],
                           col_left[s2_dn],  col_center[s2_dn],  col_right[s2_dn]);
  end

  assign push = s2_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + 1'b1;
      end else if (!push && pop) begin
        fifo_count <= fifo_count - 1'b1;
      end
    end
    if (push) begin
      fifo_q[wr_ptr] <= res;
    end
  end

  // hold input once the queue could not take every result still in flight
  assign s_axis_tready = (fifo_count + CNT_W'(s1_valid) + CNT_W'(s2_valid)) <
                         CNT_W'(FIFO_DEPTH);

  assign m_axis_tvalid = (fifo_count != '0);
  assign m_axis_tdata  = {7'b0, fifo_q[rd_ptr].pixel};
  assign m_axis_tlast  = fifo_q[rd_ptr].last;

endmodule

>>> bench/tb_binary_bridge_3x3_unit.sv
// Self-checking bench for binary_bridge_3x3_unit: random binary frames, a bridge predictor
// kept in a scoreboard class, and random idling on both stream sides.
// Depends on bb3_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_binary_bridge_3x3_unit;
  import bb3_pkg::*;

  localparam int MAX_COLS        = 1024;
  localparam int MAX_ROWS        = 1024;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int RANDOM_PIXELS   = 950;
  localparam int SHORT_RUN       = 24;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = 8'd0;    // [0] pixel_in
  logic                    s_axis_tuser = ACT_PIXEL; // [0] action
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;           // [0] pixel_out
  logic                    m_axis_tlast;
  logic                    cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_addr = REG_FRAME_COLS;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int unsigned             idle_pct = 0;
  int unsigned             stall_pct = 0;
  bit                      hold_req = 1'b0;
  logic [CFG_DATA_W-1:0]   cur_cols = 11'd1024;
  logic [CFG_DATA_W-1:0]   cur_rows = 11'd1024;

  // zero acts as one, anything past the maximum acts as the maximum
  function automatic int unsigned clamp_span(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  class bridge_scoreboard;
    logic [CFG_DATA_W-1:0] cols_reg;
    logic [CFG_DATA_W-1:0] rows_reg;
    bit                    ring [0:3][0:MAX_COLS-1];
    int unsigned           in_col, in_row, out_col, out_row;
    bit                    frame_in;
    out_beat_t             bridged_q[$];
    int unsigned           mismatches;

    function new();
      cols_reg = 11'd1024;
      rows_reg = 11'd1024;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_in = 1'b0;
    endfunction

    // a write aborts the frame in progress; the row ring keeps its contents
    function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FRAME_COLS) cols_reg = val;
      else if (idx == REG_FRAME_ROWS) rows_reg = val;
      else return;
      restart();
    endfunction

    function bit px_at(int r, int c, int nr, int nc);
      if (r < 0) r = 0;
      if (c < 0) c = 0;
      if (r > nr - 1) r = nr - 1;
      if (c > nc - 1) c = nc - 1;
      return ring[r % 4][c];
    endfunction

    function bit bridge_at(int r, int c, int nr, int nc);
      bit ctr, n, s, e, w, ne, nw, se, sw;
      bit arms_clear, diag_gap, horiz, vert, corner;
      ctr = px_at(r, c, nr, nc);
      n   = px_at(r - 1, c, nr, nc);
      s   = px_at(r + 1, c, nr, nc);
      e   = px_at(r, c + 1, nr, nc);
      w   = px_at(r, c - 1, nr, nc);
      ne  = px_at(r - 1, c + 1, nr, nc);
      nw  = px_at(r - 1, c - 1, nr, nc);
      se  = px_at(r + 1, c + 1, nr, nc);
      sw  = px_at(r + 1, c - 1, nr, nc);
      arms_clear = !ctr && !n && !s && !e && !w;
      // two diagonal neighbors on one side only: leave the gap open
      diag_gap = arms_clear && ((ne && nw && !se && !sw) || (nw && sw && !ne && !se) ||
                                (sw && se && !ne && !nw) || (ne && se && !nw && !sw));
      horiz = !n && !s && (nw || w || sw) && (ne || e || se) && !diag_gap;
      vert  = !w && !e && (nw || n || ne) && (sw || s || se) && !diag_gap;
      corner = (se && !e && !s && (n || nw || w)) ||
               (ne && !e && !n && (w || sw || s)) ||
               (nw && !n && !w && (e || s || se)) ||
               (sw && !w && !s && (e || ne || n));
      return ctr || horiz || vert || corner;
    endfunction

    function void note_stream_beat(logic act, logic px);
      int unsigned nc, nr, got, nxt_r, nxt_c;
      out_beat_t   b;
      nc = clamp_span(cols_reg, MAX_COLS);
      nr = clamp_span(rows_reg, MAX_ROWS);
      // pixels after the last one of a complete frame count as flush beats
      if (act == ACT_PIXEL && !frame_in) begin
        ring[in_row % 4][in_col] = px;
        in_col++;
        if (in_col >= nc) begin
          in_col = 0;
          in_row++;
          if (in_row >= nr) frame_in = 1'b1;
        end
      end
      if (!frame_in) begin
        got   = in_row * nc + in_col;
        nxt_r = (out_row + 1 < nr) ? out_row + 1 : nr - 1;
        nxt_c = (out_col + 1 < nc) ? out_col + 1 : nc - 1;
        if (got <= nxt_r * nc + nxt_c) return;
      end
      b.pixel = bridge_at(out_row, out_col, nr, nc);
      b.last  = (out_row == nr - 1) && (out_col == nc - 1);
      bridged_q.push_back(b);
      if (b.last) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= nc) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_out_beat(logic px, logic last);
      out_beat_t want;
      if (bridged_q.size() == 0) begin
        $error("unexpected output beat: pixel_out=%0d last_of_frame=%0d", px, last);
        mismatches++;
        return;
      end
      want = bridged_q.pop_front();
      if (px !== want.pixel) begin
        $error("pixel_out: expected %0d, got %0d", want.pixel, px);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_frame: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  bridge_scoreboard sb = new();

  binary_bridge_3x3_unit #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_register(cfg_addr, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_stream_beat(s_axis_tuser, s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_out_beat(m_axis_tdata[0], m_axis_tlast);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_binary_bridge_3x3_unit: FAIL");
    $finish;
  end

  task automatic send_beat(logic act, logic px);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold the input until every expected beat is out, then let the pipeline settle
  task automatic wait_results_done();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.bridged_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_geometry(bit do_cols, logic [CFG_DATA_W-1:0] cv,
                                bit do_rows, logic [CFG_DATA_W-1:0] rv);
    if (do_cols) begin
      cfg_we   <= 1'b1;
      cfg_addr <= REG_FRAME_COLS;
      cfg_data <= cv;
      @(posedge clk);
      cur_cols = cv;
    end
    if (do_rows) begin
      cfg_we   <= 1'b1;
      cfg_addr <= REG_FRAME_ROWS;
      cfg_data <= rv;
      @(posedge clk);
      cur_rows = rv;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(bit cut_short, inout int unsigned sent);
    int unsigned fc, fr, keep, dens, i;
    logic        act;
    fc   = clamp_span(cur_cols, MAX_COLS);
    fr   = clamp_span(cur_rows, MAX_ROWS);
    dens = $urandom_range(15, 75);
    keep = (cut_short && fc * fr > 1) ? $urandom_range(1, fc * fr - 1) : fc * fr;
    for (i = 0; i < keep; i++) begin
      if ($urandom_range(15) == 0) send_beat(ACT_FLUSH, 1'($urandom_range(1)));
      send_beat(ACT_PIXEL, $urandom_range(99) < dens);
    end
    sent += keep;
    if (keep == fc * fr) begin
      // drain; early pixel beats land while the frame is still draining
      for (i = 0; i < fc + 3; i++) begin
        act = (fr > 1 && i < fc / 2 && $urandom_range(3) == 0) ? ACT_PIXEL : ACT_FLUSH;
        send_beat(act, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int unsigned       g, frames, n, sent, pick, which, k, i;
    logic [8:0]        pattern;
    logic [CFG_DATA_W-1:0] cv, rv;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: far too early for any result
    send_beat(ACT_PIXEL, 1'b1);
    send_beat(ACT_PIXEL, 1'b0);
    send_beat(ACT_FLUSH, 1'b1);
    send_beat(ACT_PIXEL, 1'b1);
    wait_results_done();

    // zero geometry acts as a single pixel; flush with nothing pending in between
    write_geometry(1'b1, 11'd0, 1'b1, 11'd0);
    send_beat(ACT_PIXEL, 1'b0);
    send_beat(ACT_FLUSH, 1'b0);
    send_beat(ACT_PIXEL, 1'b1);
    wait_results_done();

    // 3x3 frame, flush mid-frame, then a pixel after the frame is complete
    write_geometry(1'b1, 11'd3, 1'b1, 11'd3);
    pattern = 9'b010_000_101;
    for (k = 0; k < 9; k++) begin
      if (k == 4) send_beat(ACT_FLUSH, 1'b1);
      send_beat(ACT_PIXEL, pattern[k]);
    end
    send_beat(ACT_PIXEL, 1'b1);
    repeat (4) send_beat(ACT_FLUSH, 1'b0);
    wait_results_done();

    sent  = 0;
    g     = 0;
    while (sent < RANDOM_PIXELS) begin
      case (g % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (g == 5) begin
        // receiver holds off while the sender keeps pushing
        idle_pct  = 0;
        stall_pct = 0;
        write_geometry(1'b1, 11'd6, 1'b1, 11'd40);
        hold_req = 1'b1;
        run_frame(1'b0, sent);
      end else if (g == 9) begin
        // out-of-range and maximum geometry: a short run into each such frame
        idle_pct  = 0;
        stall_pct = 13;
        for (k = 0; k < 3; k++) begin
          case (k)
            0: write_geometry(1'b1, 11'd2047, 1'b1, 11'd1);
            1: write_geometry(1'b1, 11'd0, 1'b1, 11'd2047);
            default: write_geometry(1'b1, 11'd1024, 1'b1, 11'd3);
          endcase
          for (i = 0; i < SHORT_RUN; i++) send_beat(ACT_PIXEL, 1'($urandom_range(1)));
          sent += SHORT_RUN;
          wait_results_done();
        end
      end else begin
        pick = $urandom_range(19);
        cv = (pick == 0) ? 11'd0 : (pick < 4) ? CFG_DATA_W'($urandom_range(13, 40)) :
                                                CFG_DATA_W'($urandom_range(1, 12));
        pick = $urandom_range(19);
        rv = (pick == 0) ? 11'd0 : (pick < 3) ? CFG_DATA_W'($urandom_range(9, 24)) :
                                                CFG_DATA_W'($urandom_range(1, 8));
        which = $urandom_range(2);
        write_geometry(which != 1, cv, which != 0, rv);
        frames = $urandom_range(1, 3);
        for (n = 0; n < frames; n++)
          run_frame(n == frames - 1 && $urandom_range(5) == 0, sent);
      end
      wait_results_done();
      g++;
    end

    repeat (12) @(posedge clk);
    if (sb.bridged_q.size() != 0) begin
      $error("%0d expected output beats never arrived", sb.bridged_q.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("tb_binary_bridge_3x3_unit: PASS");
    end else begin
      $display("tb_binary_bridge_3x3_unit: FAIL");
    end
    $finish;
  end

endmodule
